[design/pp_pkg.sv]
// ----------------------------------------------------------------------------
// pp_pkg
// Shared types for the polygon perimeter block: controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pp_pkg;

    // extra radicand shift, gives 8 more fraction bits on each root
    localparam int unsigned RAD_SHIFT = 16;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIFF  = 8'b0000_0010,
        ST_MULX  = 8'b0000_0100,
        ST_MULY  = 8'b0000_1000,
        ST_START = 8'b0001_0000,
        ST_ROOT  = 8'b0010_0000,
        ST_ACC   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } pp_state_t;

    typedef struct packed {
        logic accept;      // input request taken this cycle
        logic seg_close;   // segment runs from current node back to first node
        logic diff_load;   // register coordinate magnitudes
        logic mul_x;       // square of dx
        logic mul_y;       // add square of dy
        logic root_start;  // load radicand into the root unit
        logic root_step;   // one root bit
        logic acc;         // add root into running sum
        logic emit;        // load result register and end the polygon
    } pp_cmd_t;

    typedef struct packed {
        logic have_first;
        logic last;
        logic root_last;   // root unit is on its final bit
    } pp_status_t;

endpackage

[design/pp_ctrl.sv]
// ----------------------------------------------------------------------------
// pp_ctrl
// Sequencer for the polygon perimeter block: walks each segment through
// difference, squaring, square root and accumulate, and owns the handshakes.
// ----------------------------------------------------------------------------
module pp_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last_node,
    input  logic               out_ready,
    input  pp_pkg::pp_status_t status,
    output pp_pkg::pp_cmd_t    cmd,
    output logic               in_ready,
    output logic               out_valid
);

    pp_pkg::pp_state_t state_reg;
    pp_pkg::pp_state_t state_next;
    logic              close_reg;
    logic              close_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == pp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        close_next     = close_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.seg_close  = close_reg;
        case (state_reg)
            pp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.have_first)
                    begin
                        close_next = 1'b0;
                        state_next = pp_pkg::ST_DIFF;
                    end
                    else if (last_node)
                    begin
                        // lone node: closing segment has zero length
                        close_next = 1'b1;
                        state_next = pp_pkg::ST_DIFF;
                    end
                end
            end
            pp_pkg::ST_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = pp_pkg::ST_MULX;
            end
            pp_pkg::ST_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = pp_pkg::ST_MULY;
            end
            pp_pkg::ST_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = pp_pkg::ST_START;
            end
            pp_pkg::ST_START:
            begin
                cmd.root_start = 1'b1;
                state_next     = pp_pkg::ST_ROOT;
            end
            pp_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = pp_pkg::ST_ACC;
                end
            end
            pp_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (close_reg)
                begin
                    state_next = pp_pkg::ST_EMIT;
                end
                else if (status.last)
                begin
                    close_next = 1'b1;
                    state_next = pp_pkg::ST_DIFF;
                end
                else
                begin
                    state_next = pp_pkg::ST_IDLE;
                end
            end
            pp_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    close_next     = 1'b0;
                    state_next     = pp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pp_pkg::ST_IDLE;
            close_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            close_reg     <= close_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a finished perimeter never overwrites one still waiting
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // new requests only taken between segments of work
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == pp_pkg::ST_IDLE || state_reg == pp_pkg::ST_DIFF))
        else $error("accept left controller in an unexpected state");

endmodule

[design/pp_datapath.sv]
// ----------------------------------------------------------------------------
// pp_datapath
// Node registers, shared squaring multiplier, bit-serial square root and the
// saturating perimeter accumulator.
// ----------------------------------------------------------------------------
module pp_datapath #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned SUM_BITS   = 40
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pp_pkg::pp_cmd_t              cmd,
    input  logic signed [COORD_BITS-1:0] node_x,
    input  logic signed [COORD_BITS-1:0] node_y,
    input  logic                         last_node,
    output pp_pkg::pp_status_t           status,
    output logic        [SUM_BITS-1:0]   perimeter,
    output logic                         saturated
);

    localparam int unsigned SQ_W    = 2 * COORD_BITS + 1;
    localparam int unsigned ROOT_W  = COORD_BITS + 9;
    localparam int unsigned RAD_W   = 2 * ROOT_W;
    localparam int unsigned REM_W   = ROOT_W + 2;
    localparam int unsigned CNT_W   = $clog2(ROOT_W + 1);
    localparam int unsigned ACC_W   = ((SUM_BITS > ROOT_W) ? SUM_BITS : ROOT_W) + 1;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                         last_reg;
    logic                         have_first_reg;
    logic        [COORD_BITS-1:0] mx_reg, my_reg;
    logic        [SQ_W-1:0]       sq_reg;
    logic        [RAD_W-1:0]      rad_reg;
    logic        [REM_W-1:0]      rem_reg;
    logic        [ROOT_W-1:0]     root_reg;
    logic        [CNT_W-1:0]      cnt_reg;
    logic        [SUM_BITS-1:0]   sum_reg;
    logic                         ovf_reg;
    logic        [SUM_BITS-1:0]   perimeter_reg;
    logic                         saturated_reg;

    logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y;
    logic signed [COORD_BITS:0]   dx, dy;
    logic        [COORD_BITS:0]   dx_mag, dy_mag;
    logic        [COORD_BITS-1:0] mul_op;
    logic        [2*COORD_BITS-1:0] prod;
    logic        [REM_W-1:0]      rem_shift, trial, rem_next;
    logic                         fits;
    logic        [ACC_W-1:0]      acc_sum;
    logic                         acc_over;

    // segment endpoints
    assign a_x = cmd.seg_close ? cur_x_reg   : prev_x_reg;
    assign a_y = cmd.seg_close ? cur_y_reg   : prev_y_reg;
    assign b_x = cmd.seg_close ? first_x_reg : cur_x_reg;
    assign b_y = cmd.seg_close ? first_y_reg : cur_y_reg;

    assign dx     = (COORD_BITS+1)'(a_x) - (COORD_BITS+1)'(b_x);
    assign dy     = (COORD_BITS+1)'(a_y) - (COORD_BITS+1)'(b_y);
    assign dx_mag = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
    assign dy_mag = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;

    // one multiplier, used for dx then dy
    assign mul_op = cmd.mul_x ? mx_reg : my_reg;
    assign prod   = mul_op * mul_op;

    // restoring square root, one bit per cycle
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);
    assign rem_next  = fits ? (rem_shift - trial) : rem_shift;

    assign acc_sum  = ACC_W'(sum_reg) + ACC_W'(root_reg);
    assign acc_over = (acc_sum[ACC_W-1:SUM_BITS] != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.accept && !have_first_reg)
            begin
                have_first_reg <= 1'b1;
                sum_reg        <= '0;
                ovf_reg        <= 1'b0;
            end
            if (cmd.root_start)
            begin
                cnt_reg <= CNT_W'(ROOT_W);
            end
            else if (cmd.root_step)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.acc)
            begin
                if (acc_over)
                begin
                    sum_reg <= '1;
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= acc_sum[SUM_BITS-1:0];
                end
            end
            if (cmd.emit)
            begin
                have_first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_x_reg <= node_x;
            cur_y_reg <= node_y;
            last_reg  <= last_node;
            if (!have_first_reg)
            begin
                first_x_reg <= node_x;
                first_y_reg <= node_y;
                prev_x_reg  <= node_x;
                prev_y_reg  <= node_y;
            end
        end
        if (cmd.acc && !cmd.seg_close)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (cmd.diff_load)
        begin
            mx_reg <= dx_mag[COORD_BITS-1:0];
            my_reg <= dy_mag[COORD_BITS-1:0];
        end
        if (cmd.mul_x)
        begin
            sq_reg <= SQ_W'(prod);
        end
        else if (cmd.mul_y)
        begin
            sq_reg <= sq_reg + SQ_W'(prod);
        end
        if (cmd.root_start)
        begin
            rad_reg  <= RAD_W'({sq_reg, {pp_pkg::RAD_SHIFT{1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
        if (cmd.emit)
        begin
            perimeter_reg <= sum_reg;
            saturated_reg <= ovf_reg;
        end
    end

    assign status.have_first = have_first_reg;
    assign status.last       = last_reg;
    assign status.root_last  = (cnt_reg == CNT_W'(1));

    assign perimeter = perimeter_reg;
    assign saturated = saturated_reg;

    // sticky overflow always comes with a pinned sum
    a_ovf_pinned: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (sum_reg == {SUM_BITS{1'b1}}))
        else $error("overflow flag set with sum below full scale");

    // root unit never stepped past its last bit
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_step |-> (cnt_reg != '0))
        else $error("root step with exhausted bit count");

    // an accepted node always leaves a polygon open
    a_first_seen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> have_first_reg)
        else $error("first node not recorded");

endmodule

[design/polygon_perimeter.sv]
// ----------------------------------------------------------------------------
// polygon_perimeter
// Closed polygon perimeter: sums floor(sqrt((dx^2+dy^2)*2^16)) over the
// segments between successive nodes and the closing segment, with saturation.
// ----------------------------------------------------------------------------
//  channel  signals                              direction
//  node     in_valid in_ready node_x node_y      in
//           last_node
//  result   out_valid out_ready perimeter        out
//           saturated
//
//  a segment runs difference, both squares, root start, the one-bit-per-cycle
//  root and accumulate; after a node that is not last, ready returns when its
//  segment is summed; a last node adds the closing segment, then emits
//  reset clears the open polygon and any pending result
//  a result waiting on out_ready holds back only the next polygon's closing
// ----------------------------------------------------------------------------
module polygon_perimeter #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned SUM_BITS   = 40
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] node_x,
    input  logic signed [COORD_BITS-1:0] node_y,
    input  logic                         last_node,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic        [SUM_BITS-1:0]   perimeter,
    output logic                         saturated
);

    pp_pkg::pp_cmd_t    cmd;
    pp_pkg::pp_status_t status;

    pp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_node (last_node),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    pp_datapath #(
        .COORD_BITS (COORD_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .node_x    (node_x),
        .node_y    (node_y),
        .last_node (last_node),
        .status    (status),
        .perimeter (perimeter),
        .saturated (saturated)
    );

endmodule
